>>> src/psrm_pkg.sv
// Shared constants, codes and unit handshake structs for the residency meter.
package psrm_pkg;

  // Field and storage sizes
  localparam int TIME_W     = 48;
  localparam int RING_DEPTH = 9;
  localparam int PCT_W      = 7;
  localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = $clog2(RING_DEPTH * 100 + 1);
  localparam int BIT_W      = $clog2(SUM_W);

  // Decimal digit unit: ten add/compare steps per digit
  localparam int STEP_W     = 4;
  localparam int DIGIT_W    = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(9);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // Action codes
  localparam logic ACT_MODE   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Percentage divider request / response
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } psrm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } psrm_div_rsp_t;

  // Ring write / average request and response
  typedef struct packed {
    logic             start;
    logic [PCT_W-1:0] pct;
  } psrm_ring_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] avg;
  } psrm_ring_rsp_t;

endpackage

>>> src/psrm_ifs.sv
// Valid/ready channel interfaces for item beats and result beats.
interface psrm_in_if import psrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] now_us;
  logic              new_mode_low_power;

  modport source (output valid, action, now_us, new_mode_low_power, input ready);
  modport sink   (input valid, action, now_us, new_mode_low_power, output ready);
endinterface

interface psrm_out_if import psrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] average_percent;
  logic             sample_recorded;

  modport source (output valid, average_percent, sample_recorded, input ready);
  modport sink   (input valid, average_percent, sample_recorded, output ready);
endinterface

>>> src/psrm_pct_div.sv
// Two-digit decimal divider: floor(100 * num / den) for num < den < 2^(TIME_W-1).
module psrm_pct_div import psrm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  psrm_div_req_t req,
  output psrm_div_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_HI, D_LO} state_t;

  state_t               state;
  logic [TIME_W-1:0]    r;
  logic [TIME_W-1:0]    e;
  logic [TIME_W-1:0]    acc;
  logic [STEP_W-1:0]    step;
  logic [DIGIT_W-1:0]   d;
  logic [DIGIT_W-1:0]   d_hi;
  logic                 done;
  logic [PCT_W-1:0]     pct;

  logic [TIME_W-1:0]    sum;
  logic                 ge;
  logic [TIME_W-1:0]    acc_next;
  logic [DIGIT_W-1:0]   d_next;
  logic [PCT_W-1:0]     pct_next;

  // One add/compare step: acc + r never overflows since both stay below den
  always_comb begin
    sum      = acc + r;
    ge       = (sum >= e);
    acc_next = ge ? (sum - e) : sum;
    d_next   = d + DIGIT_W'(ge);
    pct_next = (PCT_W'(d_hi) << 3) + (PCT_W'(d_hi) << 1) + PCT_W'(d_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      // done pulses on the last step of the low digit
      done <= (state == D_LO) && (step == STEP_LAST);
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            r     <= req.num;
            e     <= req.den;
            acc   <= '0;
            step  <= '0;
            d     <= '0;
            state <= D_HI;
          end
        end
        D_HI, D_LO: begin
          if (step == STEP_LAST) begin
            // digit finished: remainder carries into the next digit
            r    <= acc_next;
            acc  <= '0;
            step <= '0;
            d    <= '0;
            if (state == D_HI) begin
              d_hi  <= d_next;
              state <= D_LO;
            end else begin
              pct   <= pct_next;
              state <= D_IDLE;
            end
          end else begin
            acc  <= acc_next;
            d    <= d_next;
            step <= step + STEP_W'(1);
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.pct  = pct;

endmodule

>>> src/psrm_ring_avg.sv
// Ring of recent percentages with a serial sum sweep and bit-serial average divider.
module psrm_ring_avg import psrm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  psrm_ring_req_t req,
  output psrm_ring_rsp_t rsp
);

  typedef enum logic [1:0] {R_IDLE, R_SUM, R_DIV} state_t;

  state_t            state;
  logic [PCT_W-1:0]  ring [RING_DEPTH];
  logic              ring_valid [RING_DEPTH];
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  idx;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rem;
  logic [BIT_W-1:0]  bit_cnt;
  logic              done;
  logic [PCT_W-1:0]  avg;

  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W-1:0]  rem_next;
  logic [SUM_W-1:0]  quot_next;

  // Restoring division step: sum shifts out dividend bits, quotient bits shift in
  always_comb begin
    rem_sh    = {rem, sum[SUM_W-1]};
    ge        = (rem_sh >= {1'b0, cnt});
    rem_next  = ge ? CNT_W'(rem_sh - {1'b0, cnt}) : CNT_W'(rem_sh);
    quot_next = {sum[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      pos   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_valid[i] <= 1'b0;
      end
    end else begin
      // done pulses on the last quotient bit
      done <= (state == R_DIV) && (bit_cnt == '0);
      unique case (state)
        R_IDLE: begin
          if (req.start) begin
            ring[pos]       <= req.pct;
            ring_valid[pos] <= 1'b1;
            pos   <= (pos == POS_W'(RING_DEPTH - 1)) ? '0 : pos + POS_W'(1);
            idx   <= '0;
            sum   <= '0;
            cnt   <= '0;
            state <= R_SUM;
          end
        end
        R_SUM: begin
          // one entry per cycle
          if (ring_valid[idx]) begin
            sum <= sum + SUM_W'(ring[idx]);
            cnt <= cnt + CNT_W'(1);
          end
          if (idx == POS_W'(RING_DEPTH - 1)) begin
            rem     <= '0;
            bit_cnt <= BIT_W'(SUM_W - 1);
            state   <= R_DIV;
          end else begin
            idx <= idx + POS_W'(1);
          end
        end
        R_DIV: begin
          rem <= rem_next;
          sum <= quot_next;
          if (bit_cnt == '0) begin
            avg   <= quot_next[PCT_W-1:0];
            state <= R_IDLE;
          end else begin
            bit_cnt <= bit_cnt - BIT_W'(1);
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.avg  = avg;

endmodule

>>> src/power_save_residency_meter.sv
// Top level of the low-power residency meter with moving-average report.
//
//  channel | dir | beat contents                                 | when
//  item    | in  | action, now_us, new_mode_low_power            | valid & ready
//  result  | out | average_percent, sample_recorded              | valid & ready
//
// One item at a time; item.ready is high only while the sequencer is idle.
// Mode change: S_EVAL, S_APPLY. Sample: S_EVAL, S_APPLY, S_SAMP, S_OUT when nothing is recorded.
// A recorded sample adds S_DELTA, the decimal divider (10 steps per digit) when the share is
// at least 0 and below 100, and the ring sweep and average division in S_RING.
// The result register frees the sequencer; a stalled result holds only the last step.
// Synchronous reset clears the meter flags, the ring valid bits, the stored timestamps and totals.
module power_save_residency_meter import psrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  psrm_in_if.sink    item,
  psrm_out_if.source result
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_APPLY, S_SAMP, S_DELTA, S_DIV, S_RING, S_OUT
  } state_t;

  state_t            state;

  // latched item
  logic              act;
  logic [TIME_W-1:0] now_q;
  logic              lp_q;

  // meter state
  logic              mode_started;
  logic              in_lp;
  logic [TIME_W-1:0] last_change;
  logic [TIME_W-1:0] lp_total;
  logic              sample_started;
  logic [TIME_W-1:0] last_sample_time;
  logic [TIME_W-1:0] last_sample_total;
  logic [PCT_W-1:0]  avg_q;

  // working values
  logic [TIME_W-1:0] open_len;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] cur_total;
  logic [TIME_W-1:0] delta;
  logic [PCT_W-1:0]  pct_q;
  logic [PCT_W-1:0]  res_avg;
  logic              res_rec;

  // result register
  logic              out_valid;
  logic [PCT_W-1:0]  out_avg;
  logic              out_rec;

  logic              div_start;
  logic              ring_start;

  psrm_div_req_t     div_req;
  psrm_div_rsp_t     div_rsp;
  psrm_ring_req_t    ring_req;
  psrm_ring_rsp_t    ring_rsp;

  assign div_req.start  = div_start;
  assign div_req.num    = delta;
  assign div_req.den    = elapsed;
  assign ring_req.start = ring_start;
  assign ring_req.pct   = pct_q;

  psrm_pct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  psrm_ring_avg u_ring (
    .clk (clk),
    .rst (rst),
    .req (ring_req),
    .rsp (ring_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      mode_started      <= 1'b0;
      in_lp             <= 1'b0;
      last_change       <= '0;
      lp_total          <= '0;
      sample_started    <= 1'b0;
      last_sample_time  <= '0;
      last_sample_total <= '0;
      avg_q             <= '0;
      out_valid         <= 1'b0;
      div_start         <= 1'b0;
      ring_start        <= 1'b0;
    end else begin
      // divider start: share at least 0 and below 100
      div_start  <= (state == S_DELTA) && !delta[TIME_W-1] && (delta < elapsed);
      // ring start: clamped share, or divider finished
      ring_start <= ((state == S_DELTA) && (delta[TIME_W-1] || (delta >= elapsed))) ||
                    ((state == S_DIV) && div_rsp.done);
      if (out_valid && result.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            act   <= item.action;
            now_q <= item.now_us;
            lp_q  <= item.new_mode_low_power;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          open_len <= now_q - last_change;
          elapsed  <= now_q - last_sample_time;
          state    <= S_APPLY;
        end
        S_APPLY: begin
          if (act == ACT_MODE) begin
            if (!mode_started) begin
              // first change opens the first interval and sets the sample baseline
              mode_started      <= 1'b1;
              sample_started    <= 1'b1;
              last_sample_time  <= now_q;
              last_sample_total <= lp_total;
            end else if (in_lp) begin
              lp_total <= lp_total + open_len;
            end
            last_change <= now_q;
            in_lp       <= lp_q;
            state       <= S_IDLE;
          end else begin
            cur_total <= lp_total + ((mode_started && in_lp) ? open_len : '0);
            state     <= S_SAMP;
          end
        end
        S_SAMP: begin
          if (!sample_started) begin
            // first sample only sets the baseline
            sample_started    <= 1'b1;
            last_sample_time  <= now_q;
            last_sample_total <= cur_total;
            res_avg           <= '0;
            res_rec           <= 1'b0;
            state             <= S_OUT;
          end else if (elapsed == '0 || elapsed[TIME_W-1]) begin
            res_avg <= avg_q;
            res_rec <= 1'b0;
            state   <= S_OUT;
          end else begin
            delta <= cur_total - last_sample_total;
            state <= S_DELTA;
          end
        end
        S_DELTA: begin
          if (delta[TIME_W-1]) begin
            pct_q <= '0;
            state <= S_RING;
          end else if (delta >= elapsed) begin
            pct_q <= PCT_FULL;
            state <= S_RING;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            pct_q <= div_rsp.pct;
            state <= S_RING;
          end
        end
        S_RING: begin
          if (ring_rsp.done) begin
            avg_q             <= ring_rsp.avg;
            res_avg           <= ring_rsp.avg;
            res_rec           <= 1'b1;
            last_sample_time  <= now_q;
            last_sample_total <= cur_total;
            state             <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_avg   <= res_avg;
            out_rec   <= res_rec;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready             = (state == S_IDLE);
  assign result.valid           = out_valid;
  assign result.average_percent = out_avg;
  assign result.sample_recorded = out_rec;

endmodule

>>> src/psrm_check.sv
// Port-level assertions for the residency meter, bound to the top level.
module psrm_check import psrm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [PCT_W-1:0] average_percent,
  input logic             sample_recorded
);

  // one item in flight: no beat taken right after another
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item accepted while previous item in flight");

  // a result only appears while the sequencer is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result raised while sequencer idle");

  // average is a percentage
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (average_percent <= PCT_FULL))
    else $error("average out of range");

  // stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(average_percent) && $stable(sample_recorded)))
    else $error("stalled result changed");

endmodule

bind power_save_residency_meter psrm_check u_psrm_check (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .average_percent (result.average_percent),
  .sample_recorded (result.sample_recorded)
);
